@@ design/hrm_pkg.sv @@
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and codes for the histogram running median filter.
// ----------------------------------------------------------------------------
package hrm_pkg;

  // in_tuser command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_SWAP  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_ADD,
    ST_SETTLE,
    ST_WALK_DN,
    ST_WALK_UP,
    ST_EMIT
  } state_t;

  // one cycle of histogram traffic: one read, at most one write, or a clear
  typedef struct packed {
    logic       clear;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic [7:0] rd_addr;
  } hist_req_t;

endpackage

@@ design/hrm_hist_mem.sv @@
// ----------------------------------------------------------------------------
// hrm_hist_mem
// Histogram bin store: one write and one registered read per cycle, per-bin
// valid flags so that one clear empties every bin, write-to-read forwarding.
// ----------------------------------------------------------------------------
module hrm_hist_mem #(
  parameter int LEVELS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hrm_pkg::hist_req_t req,
  output logic [7:0]        rd_data
);

  localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [7:0]        mem [LEVELS];
  logic [LEVELS-1:0] valid_r;
  logic [7:0]        rd_q_r;
  logic              rd_vld_r;
  logic              fwd_hit_r;
  logic [7:0]        fwd_data_r;

  logic [LVL_W-1:0] wa;
  logic [LVL_W-1:0] ra;

  assign wa = req.wr_addr[LVL_W-1:0];
  assign ra = req.rd_addr[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wa] <= req.wr_data;
    end
    rd_q_r     <= mem[ra];
    fwd_data_r <= req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      rd_vld_r  <= valid_r[ra];
      fwd_hit_r <= req.wr_en && (wa == ra);
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[wa] <= 1'b1;
      end
    end
  end

  // same-edge write wins; a bin never written since clear reads as zero
  assign rd_data = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_q_r : 8'd0);

endmodule

@@ design/histogram_running_median.sv @@
// ----------------------------------------------------------------------------
// histogram_running_median
// Running median over a KxK window of 8-bit pixels, kept as a bin histogram.
// ----------------------------------------------------------------------------
// Throughput: one beat at a time. Without in_tlast a clear or no-op keeps the
//   block in ST_IDLE, an add does one read-modify-write of the bin memory and a swap two.
// With in_tlast the beat adds a walk: ST_SETTLE, then one ST_WALK_DN or ST_WALK_UP
//   state per median step (the walk up ends on a bin it rejects); out_tvalid rises
//   when the walk ends, through ST_EMIT if an earlier result is still stalled.
// Reset (rst_n low, synchronous): all bins empty via valid flags, median and
//   count below it zero, kernel_size 3, no result pending. No clearing pass.
// ----------------------------------------------------------------------------
module histogram_running_median #(
  parameter int MAX_KERNEL = 15,
  parameter int LEVELS     = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] old_pixel, [15:8] new_pixel
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic        in_tlast,   // window_done
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] median
  // kernel_size register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam logic [7:0] TOP     = 8'(LEVELS - 1);
  localparam logic [3:0] KMAX    = 4'(MAX_KERNEL);
  localparam logic [3:0] K_RESET = 4'd3;

  hrm_pkg::state_t    state_r, state_nxt;
  hrm_pkg::hist_req_t hist_req;
  logic [7:0]         hist_rd;

  logic [3:0] kernel_r;
  logic [7:0] m_r, m_nxt;       // current median
  logic [7:0] c_r, c_nxt;       // window pixels strictly below median
  logic [7:0] old_r, new_r;
  logic       done_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;
  logic       load;

  logic       accept;
  logic       out_free;
  logic [7:0] in_old_lv, in_new_lv;
  logic [3:0] k_eff;
  logic [7:0] rank;

  // walk step values
  logic [7:0] dn_m, dn_c;
  logic       dn_more;
  logic [8:0] up_sum;
  logic       up_more;
  logic       settle_dn;
  logic       finish;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == hrm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // pixels at or above LEVELS saturate to the top bin
  assign in_old_lv = ({1'b0, in_tdata[7:0]}  >= 9'(LEVELS)) ? TOP : in_tdata[7:0];
  assign in_new_lv = ({1'b0, in_tdata[15:8]} >= 9'(LEVELS)) ? TOP : in_tdata[15:8];

  // target rank floor(K*K/2), K capped at MAX_KERNEL
  assign k_eff = (kernel_r > KMAX) ? KMAX : kernel_r;
  assign rank  = 8'(({4'd0, k_eff} * {4'd0, k_eff}) >> 1);

  // downward step: move to m-1, drop that bin from the count
  assign dn_m    = m_r - 8'd1;
  assign dn_c    = (c_r > hist_rd) ? (c_r - hist_rd) : 8'd0;
  assign dn_more = (dn_c > rank) && (dn_m != 8'd0);

  // upward step: take bin m if it keeps the count within rank
  assign up_sum  = {1'b0, c_r} + {1'b0, hist_rd};
  assign up_more = (m_r != TOP) && (up_sum <= {1'b0, rank});

  assign settle_dn = (c_r > rank);

  always_comb begin
    unique case (state_r)
      hrm_pkg::ST_SETTLE:  finish = settle_dn && (m_r == 8'd0);
      hrm_pkg::ST_WALK_DN: finish = !dn_more;
      hrm_pkg::ST_WALK_UP: finish = !up_more;
      hrm_pkg::ST_EMIT:    finish = 1'b1;
      default:             finish = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrm_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            hrm_pkg::CMD_ADD:  state_nxt = hrm_pkg::ST_ADD;
            hrm_pkg::CMD_SWAP: state_nxt = hrm_pkg::ST_REMOVE;
            default:           state_nxt = in_tlast ? hrm_pkg::ST_SETTLE : hrm_pkg::ST_IDLE;
          endcase
        end
      end
      hrm_pkg::ST_REMOVE: state_nxt = hrm_pkg::ST_ADD;
      hrm_pkg::ST_ADD:    state_nxt = done_r ? hrm_pkg::ST_SETTLE : hrm_pkg::ST_IDLE;
      hrm_pkg::ST_SETTLE: begin
        if (!settle_dn) begin
          state_nxt = hrm_pkg::ST_WALK_UP;
        end else if (!finish) begin
          state_nxt = hrm_pkg::ST_WALK_DN;
        end else begin
          state_nxt = out_free ? hrm_pkg::ST_IDLE : hrm_pkg::ST_EMIT;
        end
      end
      hrm_pkg::ST_WALK_DN,
      hrm_pkg::ST_WALK_UP,
      hrm_pkg::ST_EMIT: begin
        if (finish) begin
          state_nxt = out_free ? hrm_pkg::ST_IDLE : hrm_pkg::ST_EMIT;
        end
      end
      default: state_nxt = hrm_pkg::ST_IDLE;
    endcase
  end

  // memory traffic, median/count updates, result load
  always_comb begin
    hist_req         = '0;
    hist_req.rd_addr = m_r;
    m_nxt            = m_r;
    c_nxt            = c_r;
    load             = 1'b0;
    unique case (state_r)
      hrm_pkg::ST_IDLE: begin
        hist_req.rd_addr = (in_tuser == hrm_pkg::CMD_SWAP) ? in_old_lv : in_new_lv;
        if (accept && (in_tuser == hrm_pkg::CMD_CLEAR)) begin
          hist_req.clear = 1'b1;
          m_nxt          = 8'd0;
          c_nxt          = 8'd0;
        end
      end
      hrm_pkg::ST_REMOVE: begin
        // fetch the entering bin now; forwarding covers old == new
        hist_req.rd_addr = new_r;
        if (hist_rd != 8'd0) begin
          hist_req.wr_en   = 1'b1;
          hist_req.wr_addr = old_r;
          hist_req.wr_data = hist_rd - 8'd1;
          if ((old_r < m_r) && (c_r != 8'd0)) begin
            c_nxt = c_r - 8'd1;
          end
        end
      end
      hrm_pkg::ST_ADD: begin
        if (hist_rd != 8'hFF) begin
          hist_req.wr_en   = 1'b1;
          hist_req.wr_addr = new_r;
          hist_req.wr_data = hist_rd + 8'd1;
          if ((new_r < m_r) && (c_r != 8'hFF)) begin
            c_nxt = c_r + 8'd1;
          end
        end
      end
      hrm_pkg::ST_SETTLE: begin
        hist_req.rd_addr = settle_dn ? dn_m : m_r;
        load             = finish && out_free;
      end
      hrm_pkg::ST_WALK_DN: begin
        // prefetch the bin below the new median
        hist_req.rd_addr = m_r - 8'd2;
        m_nxt            = dn_m;
        c_nxt            = dn_c;
        load             = finish && out_free;
      end
      hrm_pkg::ST_WALK_UP: begin
        hist_req.rd_addr = m_r + 8'd1;
        if (up_more) begin
          m_nxt = m_r + 8'd1;
          c_nxt = up_sum[7:0];
        end
        load = finish && out_free;
      end
      hrm_pkg::ST_EMIT: load = out_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  hrm_hist_mem #(
    .LEVELS (LEVELS)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hist_req),
    .rd_data (hist_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrm_pkg::ST_IDLE;
      kernel_r    <= K_RESET;
      m_r         <= 8'd0;
      c_r         <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      m_r         <= m_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        kernel_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      old_r  <= in_old_lv;
      new_r  <= in_new_lv;
      done_r <= in_tlast;
    end
    if (load) begin
      out_data_r <= m_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ design/hrm_checker.sv @@
// ----------------------------------------------------------------------------
// hrm_checker
// Port-level checks for the histogram running median filter.
// ----------------------------------------------------------------------------
module hrm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // clear or no-op without window end leaves the input ready in the next cycle
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast &&
    (in_tuser == hrm_pkg::CMD_CLEAR || in_tuser == hrm_pkg::CMD_NOP)
    |=> in_tready)
    else $error("short command did not return to idle");

  // an add or swap moves on to a bin update state, during which the input is not ready
  a_rmw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == hrm_pkg::CMD_ADD || in_tuser == hrm_pkg::CMD_SWAP)
    |=> !in_tready)
    else $error("accepted beat during bin update");

  // no result appears in the cycle right after a beat is taken
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result raised too early");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind histogram_running_median hrm_checker u_hrm_checker (.*);
